// ===== rtl/cu256_pkg.sv =====
// Types and constants shared by the checked 256-bit ALU.
// No dependencies.
`timescale 1ns / 1ps

package cu256_pkg;

    localparam int LIMB_COUNT = 4;
    localparam int LIMB_BITS  = 64;
    localparam int DATA_BITS  = LIMB_COUNT * LIMB_BITS;
    localparam int FIT_BITS   = 64;
    localparam int CNT_BITS   = 9;

    typedef logic [3:0] t_op;
    typedef logic [1:0] t_status;

    localparam t_op OP_ADD   = 4'd0;
    localparam t_op OP_SUB   = 4'd1;
    localparam t_op OP_MUL   = 4'd2;
    localparam t_op OP_DIV   = 4'd3;
    localparam t_op OP_MOD   = 4'd4;
    localparam t_op OP_LT    = 4'd5;
    localparam t_op OP_LE    = 4'd6;
    localparam t_op OP_EQ    = 4'd7;
    localparam t_op OP_AND   = 4'd8;
    localparam t_op OP_OR    = 4'd9;
    localparam t_op OP_XOR   = 4'd10;
    localparam t_op OP_NOT   = 4'd11;
    localparam t_op OP_SHL   = 4'd12;
    localparam t_op OP_SHR   = 4'd13;
    localparam t_op OP_ZERO  = 4'd14;
    localparam t_op OP_FIT64 = 4'd15;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_OVF  = 2'd1;
    localparam t_status ST_UNF  = 2'd2;
    localparam t_status ST_DIV0 = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
    } t_dp_ctrl;

    typedef struct packed {
        logic [DATA_BITS-1:0] value;
        t_status              status;
        logic                 truth;
    } t_result;

endpackage

// ===== rtl/checked_uint256_alu_core.sv =====
// Top level of the checked 256-bit ALU: sequencer, handshakes, output register.
// Depends on cu256_pkg and cu256_dp.
//
//  channel | direction | handshake                | payload
//  in      | to core   | i_in_valid / o_in_stall  | i_op, i_a_limb_*, i_b_limb_*, i_shift_amount
//  out     | from core | o_out_valid / i_out_stall| o_r_limb_*, o_status, o_truth
//
// One item at a time. Multiply, divide and modulo raise o_out_valid after the transfer
// through 256 radix-2 steps of the shared 258-bit adder, then the output load.
// Shifts move one bit per cycle, capped at 256 bits; all else goes straight to the output load.
// The next transfer can follow in the cycle after the result is loaded.
// A full, stalled output register holds the finished item; a later item then waits and keeps the input stalled.
// Reset is synchronous, active low, and empties both sides.
`timescale 1ns / 1ps

module checked_uint256_alu_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  cu256_pkg::t_op                 i_op,
    input  logic [cu256_pkg::LIMB_BITS-1:0] i_a_limb_0,
    input  logic [cu256_pkg::LIMB_BITS-1:0] i_a_limb_1,
    input  logic [cu256_pkg::LIMB_BITS-1:0] i_a_limb_2,
    input  logic [cu256_pkg::LIMB_BITS-1:0] i_a_limb_3,
    input  logic [cu256_pkg::LIMB_BITS-1:0] i_b_limb_0,
    input  logic [cu256_pkg::LIMB_BITS-1:0] i_b_limb_1,
    input  logic [cu256_pkg::LIMB_BITS-1:0] i_b_limb_2,
    input  logic [cu256_pkg::LIMB_BITS-1:0] i_b_limb_3,
    input  logic [8:0]                     i_shift_amount,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [cu256_pkg::LIMB_BITS-1:0] o_r_limb_0,
    output logic [cu256_pkg::LIMB_BITS-1:0] o_r_limb_1,
    output logic [cu256_pkg::LIMB_BITS-1:0] o_r_limb_2,
    output logic [cu256_pkg::LIMB_BITS-1:0] o_r_limb_3,
    output cu256_pkg::t_status             o_status,
    output logic                           o_truth
);
    import cu256_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;

    logic [1:0]          r_state, n_state;
    logic [CNT_BITS-1:0] r_cnt, n_cnt, steps;
    logic                r_out_valid, n_out_valid;
    t_result             r_res, dp_res;
    t_dp_ctrl            ctrl;
    logic                in_xfer, done;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign done       = (r_state == S_RUN) && (r_cnt == '0)
                        && (!r_out_valid || !i_out_stall);

    always_comb begin
        unique case (i_op) inside
            OP_MUL, OP_DIV, OP_MOD: steps = CNT_BITS'(DATA_BITS);
            OP_SHL, OP_SHR:
                steps = (i_shift_amount >= CNT_BITS'(DATA_BITS))
                        ? CNT_BITS'(DATA_BITS) : i_shift_amount;
            default: steps = '0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        ctrl.load   = in_xfer;
        ctrl.step   = (r_state == S_RUN) && (r_cnt != '0);
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = S_RUN;
                    n_cnt   = steps;
                end
            end
            S_RUN: begin
                if (r_cnt != '0) begin
                    n_cnt = r_cnt - 1'b1;
                end else if (done) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) r_res <= dp_res;
    end

    cu256_dp u_dp (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .i_op   (i_op),
        .i_a    ({i_a_limb_3, i_a_limb_2, i_a_limb_1, i_a_limb_0}),
        .i_b    ({i_b_limb_3, i_b_limb_2, i_b_limb_1, i_b_limb_0}),
        .o_res  (dp_res)
    );

    assign o_out_valid = r_out_valid;
    assign o_r_limb_0  = r_res.value[1*LIMB_BITS-1:0*LIMB_BITS];
    assign o_r_limb_1  = r_res.value[2*LIMB_BITS-1:1*LIMB_BITS];
    assign o_r_limb_2  = r_res.value[3*LIMB_BITS-1:2*LIMB_BITS];
    assign o_r_limb_3  = r_res.value[4*LIMB_BITS-1:3*LIMB_BITS];
    assign o_status    = r_res.status;
    assign o_truth     = r_res.truth;

endmodule

// ===== rtl/cu256_dp.sv =====
// Operand shift registers, shared 258-bit adder and result select.
// Depends on cu256_pkg.
`timescale 1ns / 1ps

module cu256_dp (
    input  logic                           i_clk,
    input  cu256_pkg::t_dp_ctrl            i_ctrl,
    input  cu256_pkg::t_op                 i_op,
    input  logic [cu256_pkg::DATA_BITS-1:0] i_a,
    input  logic [cu256_pkg::DATA_BITS-1:0] i_b,
    output cu256_pkg::t_result             o_res
);
    import cu256_pkg::*;

    // r_acc: product high half or partial remainder; r_sh: a, product low half,
    // quotient or shifted value
    logic [DATA_BITS:0]   r_acc, n_acc;
    logic [DATA_BITS-1:0] r_sh, n_sh;
    logic [DATA_BITS-1:0] r_b;
    t_op                  r_op;

    logic [DATA_BITS+1:0] x, y, sum;
    logic                 sub, qbit;

    always_comb begin
        x   = {2'b00, r_sh};
        y   = {2'b00, r_b};
        sub = 1'b0;
        unique case (r_op) inside
            OP_SUB, OP_LT, OP_LE: sub = 1'b1;
            OP_MUL: begin
                x = {1'b0, r_acc};
                y = r_sh[0] ? {2'b00, r_b} : '0;
            end
            OP_DIV, OP_MOD: begin
                x   = {1'b0, r_acc[DATA_BITS-1:0], r_sh[DATA_BITS-1]};
                sub = 1'b1;
            end
            default: sub = 1'b0;
        endcase
        sum  = x + (sub ? ~y : y) + {{(DATA_BITS+1){1'b0}}, sub};
        qbit = ~sum[DATA_BITS+1];
    end

    always_comb begin
        n_acc = r_acc;
        n_sh  = r_sh;
        if (i_ctrl.step) begin
            unique case (r_op) inside
                OP_MUL: begin
                    n_acc = {1'b0, sum[DATA_BITS:1]};
                    n_sh  = {sum[0], r_sh[DATA_BITS-1:1]};
                end
                OP_DIV, OP_MOD: begin
                    n_acc = {1'b0, qbit ? sum[DATA_BITS-1:0] : x[DATA_BITS-1:0]};
                    n_sh  = {r_sh[DATA_BITS-2:0], qbit};
                end
                OP_SHL:  n_sh = {r_sh[DATA_BITS-2:0], 1'b0};
                OP_SHR:  n_sh = {1'b0, r_sh[DATA_BITS-1:1]};
                default: n_sh = r_sh;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_acc <= '0;
            r_sh  <= i_a;
            r_b   <= i_b;
            r_op  <= i_op;
        end else begin
            r_acc <= n_acc;
            r_sh  <= n_sh;
        end
    end

    always_comb begin
        o_res = '0;
        unique case (r_op)
            OP_ADD: begin
                o_res.value = sum[DATA_BITS-1:0];
                if (sum[DATA_BITS]) o_res.status = ST_OVF;
            end
            OP_SUB: begin
                o_res.value = sum[DATA_BITS-1:0];
                if (sum[DATA_BITS+1]) o_res.status = ST_UNF;
            end
            OP_MUL: begin
                o_res.value = r_sh;
                if (r_acc != '0) o_res.status = ST_OVF;
            end
            OP_DIV: begin
                o_res.value = r_sh;
                if (r_b == '0) o_res.status = ST_DIV0;
            end
            OP_MOD: begin
                o_res.value = r_acc[DATA_BITS-1:0];
                if (r_b == '0) o_res.status = ST_DIV0;
            end
            OP_LT:   o_res.truth = sum[DATA_BITS+1];
            OP_LE:   o_res.truth = sum[DATA_BITS+1] | (r_sh == r_b);
            OP_EQ:   o_res.truth = (r_sh == r_b);
            OP_AND:  o_res.value = r_sh & r_b;
            OP_OR:   o_res.value = r_sh | r_b;
            OP_XOR:  o_res.value = r_sh ^ r_b;
            OP_NOT:  o_res.value = ~r_sh;
            OP_SHL:  o_res.value = r_sh;
            OP_SHR:  o_res.value = r_sh;
            OP_ZERO: o_res.truth = (r_sh == '0);
            OP_FIT64: begin
                o_res.truth = (r_sh[DATA_BITS-1:FIT_BITS] == '0);
                o_res.value = r_sh;
                if (!o_res.truth) o_res.status = ST_OVF;
            end
            default: o_res = '0;
        endcase
        if (o_res.status != ST_OK) o_res.value = '0;
    end

endmodule

// ===== rtl/cu256_chk.sv =====
// Port-level checker for the checked 256-bit ALU, bound to the top level.
// Depends on cu256_pkg.
`timescale 1ns / 1ps

module cu256_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [cu256_pkg::LIMB_BITS-1:0] o_r_limb_0,
    input logic [cu256_pkg::LIMB_BITS-1:0] o_r_limb_1,
    input logic [cu256_pkg::LIMB_BITS-1:0] o_r_limb_2,
    input logic [cu256_pkg::LIMB_BITS-1:0] o_r_limb_3,
    input cu256_pkg::t_status             o_status,
    input logic                           o_truth
);
    import cu256_pkg::*;

    // a failed operation reports a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
        o_r_limb_0 == '0 && o_r_limb_1 == '0 && o_r_limb_2 == '0 && o_r_limb_3 == '0)
        else $error("nonzero value with error status");

    a_truth_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_truth |-> o_status == ST_OK)
        else $error("truth set with error status");

    // busy right after a transfer in
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not held off after transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
        && $stable(o_r_limb_0) && $stable(o_truth))
        else $error("stalled result changed");

endmodule

bind checked_uint256_alu_core cu256_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_r_limb_0  (o_r_limb_0),
    .o_r_limb_1  (o_r_limb_1),
    .o_r_limb_2  (o_r_limb_2),
    .o_r_limb_3  (o_r_limb_3),
    .o_status    (o_status),
    .o_truth     (o_truth)
);

// ===== tb/tb_top.sv =====
// Self-checking testbench for checked_uint256_alu_core: directed table, then random traffic.
// Depends on cu256_pkg and the core RTL; results are checked against fixed expectations or a built-in predictor.
`timescale 1ns / 1ps

module tb_top;
    import cu256_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int RANDOM_ITEMS = 1750;
    localparam int DRAIN_CYCLES = 300;
    localparam int CYCLE_LIMIT  = 4000000;

    typedef logic [DATA_BITS-1:0] t_word;

    typedef struct {
        t_op     op;
        t_word   a;
        t_word   b;
        logic [8:0] sh;
        bit      fixed;
        t_result res;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_op  i_op = OP_ADD;
    logic [LIMB_BITS-1:0] i_a_limb_0 = '0, i_a_limb_1 = '0, i_a_limb_2 = '0, i_a_limb_3 = '0;
    logic [LIMB_BITS-1:0] i_b_limb_0 = '0, i_b_limb_1 = '0, i_b_limb_2 = '0, i_b_limb_3 = '0;
    logic [8:0] i_shift_amount = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [LIMB_BITS-1:0] o_r_limb_0, o_r_limb_1, o_r_limb_2, o_r_limb_3;
    t_status o_status;
    logic o_truth;

    t_result pending_results[$];
    int      error_count = 0;
    int      cycle_count = 0;
    int      send_idle_pct = 0;
    int      stall_pct = 0;
    bit      cur_fixed = 0;
    t_result cur_result;

    checked_uint256_alu_core dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic t_result alu_predict(t_op op, t_word a, t_word b, logic [8:0] sh);
        t_result r;
        logic [DATA_BITS:0]     sum;
        logic [2*DATA_BITS-1:0] prod;
        r = '{value: '0, status: ST_OK, truth: 1'b0};
        case (op)
            OP_ADD: begin
                sum = {1'b0, a} + {1'b0, b};
                if (sum[DATA_BITS]) r.status = ST_OVF; else r.value = sum[DATA_BITS-1:0];
            end
            OP_SUB: begin
                if (a < b) r.status = ST_UNF; else r.value = a - b;
            end
            OP_MUL: begin
                prod = {{DATA_BITS{1'b0}}, a} * {{DATA_BITS{1'b0}}, b};
                if (prod[2*DATA_BITS-1:DATA_BITS] != '0) r.status = ST_OVF;
                else r.value = prod[DATA_BITS-1:0];
            end
            OP_DIV, OP_MOD: begin
                if (b == '0) r.status = ST_DIV0;
                else r.value = (op == OP_DIV) ? a / b : a % b;
            end
            OP_LT:  r.truth = (a < b);
            OP_LE:  r.truth = (a <= b);
            OP_EQ:  r.truth = (a == b);
            OP_AND: r.value = a & b;
            OP_OR:  r.value = a | b;
            OP_XOR: r.value = a ^ b;
            OP_NOT: r.value = ~a;
            OP_SHL: r.value = (sh >= DATA_BITS) ? '0 : a << sh;
            OP_SHR: r.value = (sh >= DATA_BITS) ? '0 : a >> sh;
            OP_ZERO: r.truth = (a == '0);
            default: begin
                if (a[DATA_BITS-1:FIT_BITS] == '0) begin
                    r.truth = 1'b1;
                    r.value = a;
                end else begin
                    r.status = ST_OVF;
                end
            end
        endcase
        return r;
    endfunction

    function automatic t_word rand_operand();
        t_word w;
        int    kind;
        kind = $urandom_range(9);
        for (int i = 0; i < DATA_BITS / 32; i++) w[i*32 +: 32] = $urandom;
        case (kind)
            0: w = '0;
            1: w = '1;
            2: w = w & t_word'(16'hffff);
            3: w = w & (t_word'({LIMB_BITS{1'b1}}) << (LIMB_BITS * $urandom_range(3)));
            4: w = t_word'(1) << $urandom_range(DATA_BITS - 1);
            5: w = w >> $urandom_range(DATA_BITS - 1);
            default: ;
        endcase
        return w;
    endfunction

    task automatic compare_field(string name, logic [LIMB_BITS-1:0] exp_v,
                                 logic [LIMB_BITS-1:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Record transfers on both channels; values are sampled before this edge's updates.
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no expectation pending");
                    error_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    compare_field("r_limb_0", exp_r.value[63:0], o_r_limb_0);
                    compare_field("r_limb_1", exp_r.value[127:64], o_r_limb_1);
                    compare_field("r_limb_2", exp_r.value[191:128], o_r_limb_2);
                    compare_field("r_limb_3", exp_r.value[255:192], o_r_limb_3);
                    compare_field("status", 64'(exp_r.status), 64'(o_status));
                    compare_field("truth", 64'(exp_r.truth), 64'(o_truth));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                if (cur_fixed) pending_results.push_back(cur_result);
                else pending_results.push_back(alu_predict(i_op,
                    {i_a_limb_3, i_a_limb_2, i_a_limb_1, i_a_limb_0},
                    {i_b_limb_3, i_b_limb_2, i_b_limb_1, i_b_limb_0}, i_shift_amount));
            end
        end
    end

    always @(posedge i_clk) i_out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[checked_uint256_alu_core] ERROR");
            $finish;
        end
    end

    // Called at a rising edge; returns at the edge of the transfer.
    task automatic send_item(t_row row);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        cur_fixed  <= row.fixed;
        cur_result <= row.res;
        i_in_valid <= 1'b1;
        i_op <= row.op;
        {i_a_limb_3, i_a_limb_2, i_a_limb_1, i_a_limb_0} <= row.a;
        {i_b_limb_3, i_b_limb_2, i_b_limb_1, i_b_limb_0} <= row.b;
        i_shift_amount <= row.sh;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic t_row mk(t_op op, t_word a, t_word b, logic [8:0] sh,
                                bit fixed = 0, t_word v = '0, t_status st = ST_OK,
                                logic tr = 1'b0);
        t_row r;
        r.op = op; r.a = a; r.b = b; r.sh = sh; r.fixed = fixed;
        r.res = '{value: v, status: st, truth: tr};
        return r;
    endfunction

    initial begin
        t_row directed[$];
        t_row row;
        t_word max_w;
        max_w = '1;
        directed = '{
            mk(OP_ADD, max_w, 1, 0, 1, '0, ST_OVF),
            mk(OP_ADD, max_w, 0, 0, 1, max_w),
            mk(OP_SUB, 0, 1, 0, 1, '0, ST_UNF),
            mk(OP_SUB, max_w, max_w, 0, 1, '0),
            mk(OP_MUL, max_w, max_w, 0, 1, '0, ST_OVF),
            mk(OP_MUL, t_word'(1) << 128, t_word'(1) << 127, 0),
            mk(OP_MUL, max_w, 1, 0),
            mk(OP_DIV, max_w, 0, 0, 1, '0, ST_DIV0),
            mk(OP_MOD, max_w, 0, 0, 1, '0, ST_DIV0),
            mk(OP_DIV, max_w, 3, 0),
            mk(OP_MOD, max_w, t_word'(64'hffff_ffff_ffff_fffd), 0),
            mk(OP_LT, 0, max_w, 0, 1, '0, ST_OK, 1'b1),
            mk(OP_LE, max_w, max_w, 0, 1, '0, ST_OK, 1'b1),
            mk(OP_EQ, max_w, 0, 0, 1, '0, ST_OK, 1'b0),
            mk(OP_AND, max_w, t_word'(64'h0123_4567_89ab_cdef) << 100, 0),
            mk(OP_OR, 0, max_w, 0),
            mk(OP_XOR, max_w, max_w >> 1, 0),
            mk(OP_NOT, 0, max_w, 0, 1, max_w),
            mk(OP_SHL, max_w, 0, 256, 1, '0),
            mk(OP_SHL, max_w, 0, 255),
            mk(OP_SHR, max_w, 0, 511, 1, '0),
            mk(OP_SHR, max_w, 0, 1),
            mk(OP_ZERO, 0, max_w, 0, 1, '0, ST_OK, 1'b1),
            mk(OP_FIT64, t_word'(1) << 64, 0, 0, 1, '0, ST_OVF, 1'b0),
            mk(OP_FIT64, t_word'({LIMB_BITS{1'b1}}), max_w, 0, 1,
               t_word'({LIMB_BITS{1'b1}}), ST_OK, 1'b1)
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) send_item(directed[i]);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 45; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 45; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                row = mk(t_op'($urandom_range(15)), rand_operand(), rand_operand(), '0);
                row.sh = ($urandom_range(1)) ? 9'($urandom_range(511))
                                             : 9'($urandom_range(70));
                if (row.op == OP_EQ && $urandom_range(1)) row.b = row.a;
                send_item(row);
            end
            // hold off the sender until everything in flight has come back
            wait_drained();
        end

        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("[checked_uint256_alu_core] OK");
        end else begin
            $display("[checked_uint256_alu_core] ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/cu256_pkg.sv
rtl/cu256_dp.sv
rtl/checked_uint256_alu_core.sv
rtl/cu256_chk.sv
tb/tb_top.sv
